// ===== rtl/core/fvn_pkg.sv =====
// Package for the fractal value noise block: shared widths, hash mixer
// constants, register codes and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package fvn_pkg;

  // Default generics
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Lattice index width: scaled 16-bit cell plus the 2^20 offset plus one
  localparam int unsigned IDX_W  = 21;
  localparam int unsigned SALT_W = 17;
  localparam logic [IDX_W-1:0] LAT_OFFSET = IDX_W'(1) << 20;

  // Splitmix-style mixer constants
  localparam logic [63:0] MIX_X  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_Y  = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] MIX_S  = 64'h165667B19E3779F9;
  localparam logic [63:0] MIX_K1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_K2 = 64'h94D049BB133111EB;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration port
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 64;

  typedef enum logic {
    REG_SEED = 1'b0,
    REG_SALT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] seed;
    logic [15:0] salt;
  } cfg_t;

endpackage

// ===== rtl/core/fvn_if.sv =====
// Valid/ready channel interfaces for cell coordinates and noise samples.
// Depends on nothing.
`timescale 1ns / 1ps

interface fvn_cell_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_x;
  logic [15:0] cell_y;
  modport source (output valid, output cell_x, output cell_y, input ready);
  modport sink   (input valid, input cell_x, input cell_y, output ready);
endinterface

interface fvn_noise_if;
  logic        valid;
  logic        ready;
  logic [15:0] noise_value;
  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

// ===== rtl/core/fractal_value_noise_2d.sv =====
// Top level of the two-octave 2-D value noise generator.
// Depends on fvn_pkg, fvn_if, fvn_cfg, fvn_front, fvn_queue and fvn_back.
//
// Each transfer on cell_i carries an integer lattice cell (cell_x, cell_y)
// and produces exactly one Q0.16 sample on noise_o, in order. The block
// takes one cell per clock cycle and delivers one sample per cycle unless
// noise_o stalls. A cell passes one front scaling stage, the four-entry
// queue, eleven back-end stages of hashing, smoothstep and blending, and
// the output register; the hashing is the six-stage 64-bit mixer in each
// of the eight corner hash pipelines. A stalled output holds the back end
// while the front keeps filling the queue. The user writes seed (byte
// address 0) and salt (address 8) over the APB port only while no samples
// are in flight; the block does not enforce it. Reads return them.
`timescale 1ns / 1ps

module fractal_value_noise_2d #(
  parameter int unsigned COORD_BITS = fvn_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = fvn_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [fvn_pkg::CFG_AW-1:0]  paddr_i,
  input  logic [fvn_pkg::CFG_DW-1:0]  pwdata_i,
  output logic [fvn_pkg::CFG_DW-1:0]  prdata_o,
  output logic                        pready_o,
  fvn_cell_if.sink                    cell_i,
  fvn_noise_if.source                 noise_o
);

  localparam int unsigned ENTRY_W = 4 * fvn_pkg::IDX_W + 4 * FRAC_BITS;

  fvn_pkg::cfg_t      cfg;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0] push_data, pop_data;

  fvn_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  fvn_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_i       (cell_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  fvn_queue #(.WIDTH(ENTRY_W), .DEPTH(fvn_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  fvn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .noise_o     (noise_o)
  );

endmodule

// ===== rtl/core/fvn_cfg.sv =====
// APB-style register file holding seed and salt.
// Depends on fvn_pkg.
`timescale 1ns / 1ps

module fvn_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [fvn_pkg::CFG_AW-1:0]  paddr_i,
  input  logic [fvn_pkg::CFG_DW-1:0]  pwdata_i,
  output logic [fvn_pkg::CFG_DW-1:0]  prdata_o,
  output logic                        pready_o,
  output fvn_pkg::cfg_t               cfg_o
);

  fvn_pkg::cfg_t    cfg_q;
  fvn_pkg::cfg_reg_e sel;
  logic             wr_en;

  // Register select is the 8-byte word bit
  assign sel   = fvn_pkg::cfg_reg_e'(paddr_i[3]);
  assign wr_en = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (sel)
        fvn_pkg::REG_SEED: cfg_q.seed <= pwdata_i;
        fvn_pkg::REG_SALT: cfg_q.salt <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      fvn_pkg::REG_SEED: prdata_o = cfg_q.seed;
      fvn_pkg::REG_SALT: prdata_o = {48'b0, cfg_q.salt};
      default:           prdata_o = '0;
    endcase
  end

  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

endmodule

// ===== rtl/core/fvn_front.sv =====
// Front end: accepts cells, scales them for both octaves and splits each
// point into lattice index and fraction. Depends on fvn_pkg and fvn_if.
`timescale 1ns / 1ps

module fvn_front #(
  parameter int unsigned COORD_BITS = fvn_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = fvn_pkg::FRAC_BITS_DEF,
  localparam int unsigned OCT_W     = 2 * fvn_pkg::IDX_W + 2 * FRAC_BITS,
  localparam int unsigned ENTRY_W   = 2 * OCT_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fvn_cell_if.sink           cell_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output logic [ENTRY_W-1:0] push_data_o
);

  localparam int unsigned XW = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int unsigned SW = FRAC_BITS - 2;   // both factors are below 0.25
  localparam int unsigned PW = XW + SW;
  localparam logic [SW-1:0] SCALE_LO = SW'(((64'd6 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [SW-1:0] SCALE_HI = SW'(((64'd18 << FRAC_BITS) + 64'd50) / 64'd100);

  logic          f_valid_q;
  logic [PW-1:0] px_q [2];
  logic [PW-1:0] py_q [2];
  logic          take;

  assign cell_i.ready = !f_valid_q || push_ready_i;
  assign take         = cell_i.valid && cell_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (cell_i.ready) begin
      f_valid_q <= cell_i.valid;
    end
  end

  // Scaled points, octave 0 at 0.06 and octave 1 at 0.18
  always_ff @(posedge clk_i) begin
    if (take) begin
      px_q[0] <= PW'(cell_i.cell_x[XW-1:0]) * PW'(SCALE_LO);
      py_q[0] <= PW'(cell_i.cell_y[XW-1:0]) * PW'(SCALE_LO);
      px_q[1] <= PW'(cell_i.cell_x[XW-1:0]) * PW'(SCALE_HI);
      py_q[1] <= PW'(cell_i.cell_y[XW-1:0]) * PW'(SCALE_HI);
    end
  end

  // Split into offset lattice index and fraction
  always_comb begin
    for (int o = 0; o < 2; o++) begin
      push_data_o[o*OCT_W +: FRAC_BITS] = py_q[o][FRAC_BITS-1:0];
      push_data_o[o*OCT_W + FRAC_BITS +: FRAC_BITS] = px_q[o][FRAC_BITS-1:0];
      push_data_o[o*OCT_W + 2*FRAC_BITS +: fvn_pkg::IDX_W] =
        fvn_pkg::IDX_W'(py_q[o][PW-1:FRAC_BITS]) + fvn_pkg::LAT_OFFSET;
      push_data_o[o*OCT_W + 2*FRAC_BITS + fvn_pkg::IDX_W +: fvn_pkg::IDX_W] =
        fvn_pkg::IDX_W'(px_q[o][PW-1:FRAC_BITS]) + fvn_pkg::LAT_OFFSET;
    end
  end

  assign push_valid_o = f_valid_q;

endmodule

// ===== rtl/core/fvn_queue.sv =====
// Small FIFO that decouples the front end from the back end.
// Depends on fvn_pkg.
`timescale 1ns / 1ps

module fvn_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = fvn_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != (AW + 1)'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== rtl/core/fvn_hash.sv =====
// Six-stage pipelined corner hash: splitmix-style mixer with 64-bit
// products cut into 32-bit partials. Depends on fvn_pkg.
`timescale 1ns / 1ps

module fvn_hash #(
  parameter int unsigned FRAC_BITS = fvn_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [63:0]                 seed_i,
  input  logic [fvn_pkg::IDX_W-1:0]   cx_i,
  input  logic [fvn_pkg::IDX_W-1:0]   cy_i,
  input  logic [fvn_pkg::SALT_W-1:0]  salt_i,
  output logic [FRAC_BITS-1:0]        hash_o
);

  localparam int unsigned XL_W = fvn_pkg::IDX_W + 32;
  localparam int unsigned SL_W = fvn_pkg::SALT_W + 32;

  logic [XL_W-1:0] xl_q, yl_q;
  logic [SL_W-1:0] sl_q;
  logic [31:0]     xh_q, yh_q, sh_q;
  logic [63:0]     h1_q, h2_q;
  logic [63:0]     ll1_q, ll2_q;
  logic [31:0]     lh1_q, hl1_q, lh2_q, hl2_q;
  logic [FRAC_BITS-1:0] hash_q;
  logic [63:0]     m1, m2, m3, h1_d, h2_d, h3;

  always_comb begin
    // input mix, then first xor-shift
    m1   = 64'(xl_q) + {xh_q, 32'b0};
    m2   = 64'(yl_q) + {yh_q, 32'b0};
    m3   = 64'(sl_q) + {sh_q, 32'b0};
    h1_d = seed_i ^ m1 ^ m2 ^ m3;
    h1_d = h1_d ^ (h1_d >> 30);
    // after first multiply
    h2_d = ll1_q + {lh1_q + hl1_q, 32'b0};
    h2_d = h2_d ^ (h2_d >> 27);
    // after second multiply
    h3   = ll2_q + {lh2_q + hl2_q, 32'b0};
    h3   = h3 ^ (h3 >> 31);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xl_q  <= XL_W'(cx_i) * XL_W'(fvn_pkg::MIX_X[31:0]);
      xh_q  <= 32'(cx_i * fvn_pkg::MIX_X[63:32]);
      yl_q  <= XL_W'(cy_i) * XL_W'(fvn_pkg::MIX_Y[31:0]);
      yh_q  <= 32'(cy_i * fvn_pkg::MIX_Y[63:32]);
      sl_q  <= SL_W'(salt_i) * SL_W'(fvn_pkg::MIX_S[31:0]);
      sh_q  <= 32'(salt_i * fvn_pkg::MIX_S[63:32]);
      h1_q  <= h1_d;
      ll1_q <= 64'(h1_q[31:0]) * 64'(fvn_pkg::MIX_K1[31:0]);
      lh1_q <= 32'(h1_q[31:0] * fvn_pkg::MIX_K1[63:32]);
      hl1_q <= 32'(h1_q[63:32] * fvn_pkg::MIX_K1[31:0]);
      h2_q  <= h2_d;
      ll2_q <= 64'(h2_q[31:0]) * 64'(fvn_pkg::MIX_K2[31:0]);
      lh2_q <= 32'(h2_q[31:0] * fvn_pkg::MIX_K2[63:32]);
      hl2_q <= 32'(h2_q[63:32] * fvn_pkg::MIX_K2[31:0]);
      hash_q <= h3[63 -: FRAC_BITS];
    end
  end

  assign hash_o = hash_q;

endmodule

// ===== rtl/core/fvn_back.sv =====
// Back end: hashes the eight corners, smoothsteps the fractions, blends
// both octaves and mixes them into the output register.
// Depends on fvn_pkg, fvn_if and fvn_hash.
`timescale 1ns / 1ps

module fvn_back #(
  parameter int unsigned FRAC_BITS = fvn_pkg::FRAC_BITS_DEF,
  localparam int unsigned OCT_W    = 2 * fvn_pkg::IDX_W + 2 * FRAC_BITS,
  localparam int unsigned ENTRY_W  = 2 * OCT_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fvn_pkg::cfg_t      cfg_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  logic [ENTRY_W-1:0] pop_data_i,
  fvn_noise_if.source        noise_o
);

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned NST = 11;
  localparam int unsigned IW  = fvn_pkg::IDX_W;
  localparam logic [F:0]   ONE1  = (F + 1)'(1) << F;
  localparam logic [F+1:0] THREE = (F + 2)'(3) << F;
  localparam logic [63:0]  WA64  = ((64'd65 << F) + 64'd50) / 64'd100;
  localparam logic [F-1:0] WA    = F'(WA64);
  localparam logic [F-1:0] WB    = F'((64'd1 << F) - WA64);

  logic en;
  logic [NST-1:0] vld_q;
  logic           out_valid_q;
  logic [15:0]    out_q;

  logic [F-1:0]   frac [4];
  logic [F-1:0]   hv [2][4];
  logic [F-1:0]   td_q [4][4];
  logic [F-1:0]   t2_q [4];
  logic [F-1:0]   t5_q [4];
  logic [F:0]     s_q [4];
  logic [2*F:0]   pa_q [2][2];
  logic [2*F:0]   pb_q [2][2];
  logic [F:0]     sy7_q [2];
  logic [F:0]     sy8_q [2];
  logic [F-1:0]   e_q [2][2];
  logic [2*F:0]   qa_q [2];
  logic [2*F:0]   qb_q [2];
  logic [F-1:0]   n_q [2];
  logic [2*F-1:0] ma_q, mb_q;
  logic [2*F+1:0] s6_prod [4];
  logic [2*F+1:0] e_sum [2][2];
  logic [2*F+1:0] n_sum [2];
  logic [2*F:0]   mix_sum;
  logic [F+16:0]  ve;
  logic [15:0]    out_d;

  // Whole pipeline moves unless a finished sample waits
  assign en          = !out_valid_q || noise_o.ready;
  assign pop_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NST-2:0], pop_valid_i};
      out_valid_q <= vld_q[NST-1];
    end
  end

  // Corner hashes per octave: corner bit 0 steps x, bit 1 steps y
  for (genvar o = 0; o < 2; o++) begin : g_oct
    logic [IW-1:0] ix, iy;
    logic [fvn_pkg::SALT_W-1:0] salt;
    assign ix   = pop_data_i[o*OCT_W + 2*F + IW +: IW];
    assign iy   = pop_data_i[o*OCT_W + 2*F +: IW];
    assign salt = fvn_pkg::SALT_W'(cfg_i.salt) + fvn_pkg::SALT_W'(o);
    assign frac[2*o]     = pop_data_i[o*OCT_W + F +: F];
    assign frac[2*o + 1] = pop_data_i[o*OCT_W +: F];
    for (genvar c = 0; c < 4; c++) begin : g_corner
      fvn_hash #(.FRAC_BITS(F)) u_hash (
        .clk_i  (clk_i),
        .en_i   (en),
        .seed_i (cfg_i.seed),
        .cx_i   (ix + IW'(c % 2)),
        .cy_i   (iy + IW'(c / 2)),
        .salt_i (salt),
        .hash_o (hv[o][c])
      );
    end
  end

  // Combinational sums between product stages
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      s6_prod[j] = (2*F + 2)'(t2_q[j]) * (2*F + 2)'(THREE - {1'b0, t5_q[j], 1'b0});
    end
    for (int o = 0; o < 2; o++) begin
      for (int r = 0; r < 2; r++) begin
        e_sum[o][r] = (2*F + 2)'(pa_q[o][r]) + (2*F + 2)'(pb_q[o][r]);
      end
      n_sum[o] = (2*F + 2)'(qa_q[o]) + (2*F + 2)'(qb_q[o]);
    end
    mix_sum = (2*F + 1)'(ma_q) + (2*F + 1)'(mb_q);
    // Q.F to Q0.16, then saturate
    ve    = ((F + 17)'(mix_sum[2*F:F]) << 16) >> F;
    out_d = (ve[F+16:16] != '0) ? 16'hFFFF : ve[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // fraction delay matching the hash depth, then smoothstep
      td_q[0] <= frac;
      for (int k = 1; k < 4; k++) td_q[k] <= td_q[k-1];
      for (int j = 0; j < 4; j++) begin
        t2_q[j] <= F'(((2*F)'(td_q[3][j]) * (2*F)'(td_q[3][j])) >> F);
        t5_q[j] <= td_q[3][j];
        s_q[j]  <= s6_prod[j][2*F:F];
      end
      for (int o = 0; o < 2; o++) begin
        // blend along x
        for (int r = 0; r < 2; r++) begin
          pa_q[o][r] <= (2*F + 1)'(hv[o][2*r])     * (2*F + 1)'(ONE1 - s_q[2*o]);
          pb_q[o][r] <= (2*F + 1)'(hv[o][2*r + 1]) * (2*F + 1)'(s_q[2*o]);
          e_q[o][r]  <= e_sum[o][r][2*F-1:F];
        end
        sy7_q[o] <= s_q[2*o + 1];
        sy8_q[o] <= sy7_q[o];
        // blend along y
        qa_q[o] <= (2*F + 1)'(e_q[o][0]) * (2*F + 1)'(ONE1 - sy8_q[o]);
        qb_q[o] <= (2*F + 1)'(e_q[o][1]) * (2*F + 1)'(sy8_q[o]);
        n_q[o]  <= n_sum[o][2*F-1:F];
      end
      // octave weights
      ma_q  <= (2*F)'(n_q[0]) * (2*F)'(WA);
      mb_q  <= (2*F)'(n_q[1]) * (2*F)'(WB);
      out_q <= out_d;
    end
  end

  assign noise_o.valid       = out_valid_q;
  assign noise_o.noise_value = out_q;

endmodule

// ===== test/fvn_checker.sv =====
// Checker for the fractal value noise block: watches the cell and noise channels,
// predicts each sample from the seed and salt it is given, and counts mismatches.
// Depends on fvn_pkg and fvn_if.
`timescale 1ns / 1ps

module fvn_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] seed_i,
  input  logic [15:0] salt_i,
  fvn_cell_if         cell_mon,
  fvn_noise_if        noise,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int unsigned F = 16;
  localparam logic [63:0] ONE_Q    = 64'd1 << F;
  localparam logic [63:0] SCALE_LO = ((64'd6 << F) + 64'd50) / 64'd100;
  localparam logic [63:0] SCALE_HI = ((64'd18 << F) + 64'd50) / 64'd100;
  localparam logic [63:0] WEIGHT_A = ((64'd65 << F) + 64'd50) / 64'd100;
  localparam logic [63:0] WEIGHT_B = ONE_Q - WEIGHT_A;

  logic [15:0] expected_samples[$];

  // Corner hash: splitmix-style mix, top F bits as Q0.F
  function automatic logic [63:0] corner_value(logic [63:0] cx, logic [63:0] cy,
                                               logic [63:0] s);
    logic [63:0] h;
    h = seed_i ^ (cx * fvn_pkg::MIX_X) ^ (cy * fvn_pkg::MIX_Y) ^ (s * fvn_pkg::MIX_S);
    h = h ^ (h >> 30);
    h = h * fvn_pkg::MIX_K1;
    h = h ^ (h >> 27);
    h = h * fvn_pkg::MIX_K2;
    h = h ^ (h >> 31);
    return h >> (64 - F);
  endfunction

  function automatic logic [63:0] smoothstep(logic [63:0] t);
    logic [63:0] t2;
    t2 = (t * t) >> F;
    return (t2 * (3 * ONE_Q - 2 * t)) >> F;
  endfunction

  function automatic logic [63:0] lerp_q(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * (ONE_Q - s) + b * s) >> F;
  endfunction

  function automatic logic [63:0] octave_value(logic [63:0] x, logic [63:0] y,
                                               logic [63:0] scale, logic [63:0] s);
    logic [63:0] px, py, ix, iy, sx, sy;
    px = x * scale;
    py = y * scale;
    ix = (px >> F) + (64'd1 << 20);
    iy = (py >> F) + (64'd1 << 20);
    sx = smoothstep(px & (ONE_Q - 1));
    sy = smoothstep(py & (ONE_Q - 1));
    return lerp_q(lerp_q(corner_value(ix, iy, s), corner_value(ix + 1, iy, s), sx),
                  lerp_q(corner_value(ix, iy + 1, s), corner_value(ix + 1, iy + 1, s), sx),
                  sy);
  endfunction

  function automatic logic [15:0] noise_sample(logic [15:0] x, logic [15:0] y);
    logic [63:0] n1, n2, v;
    n1 = octave_value(64'(x), 64'(y), SCALE_LO, 64'(salt_i));
    n2 = octave_value(64'(x), 64'(y), SCALE_HI, 64'(salt_i) + 1);
    v  = (n1 * WEIGHT_A + n2 * WEIGHT_B) >> F;
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  assign pending_o = expected_samples.size();

  // Predict on cell transfers, compare on noise transfers
  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      expected_samples.delete();
    end else begin
      if (cell_mon.valid && cell_mon.ready)
        expected_samples.push_back(noise_sample(cell_mon.cell_x, cell_mon.cell_y));
      if (noise.valid && noise.ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected noise sample %h", $time, noise.noise_value);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_samples.pop_front();
          if (want !== noise.noise_value) begin
            $display("%0t: noise_value expected %h actual %h", $time, want,
                     noise.noise_value);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb.sv =====
// Testbench top for fractal_value_noise_2d: drives cells and APB writes,
// stalls the output at random, and reports the verdict from fvn_checker.
// Depends on fvn_pkg, fvn_if, fvn_checker and the block.
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY = 20;
  localparam int LIMIT   = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [fvn_pkg::CFG_AW-1:0] paddr = '0;
  logic [fvn_pkg::CFG_DW-1:0] pwdata = '0;
  logic [fvn_pkg::CFG_DW-1:0] prdata;
  logic pready;
  logic [63:0] seed_shadow = '0;
  logic [15:0] salt_shadow = '0;
  int fail_count, pending, cycle_count = 0;
  logic stall_on = 1'b1;

  fvn_cell_if  cell_ch ();
  fvn_noise_if noise_ch ();

  fractal_value_noise_2d dut (
    .clk_i(clk), .rst_ni(rst_n), .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite),
    .paddr_i(paddr), .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready),
    .cell_i(cell_ch.sink), .noise_o(noise_ch.source)
  );

  fvn_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .seed_i(seed_shadow), .salt_i(salt_shadow),
    .cell_mon(cell_ch), .noise(noise_ch), .fail_count_o(fail_count), .pending_o(pending)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("** fractal_value_noise_2d: FAILED **");
      $finish;
    end
  end

  // Output-side stalls: random waits per sample, none while stall_on is low
  initial begin
    int gap;
    noise_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      gap = stall_on ? $urandom_range(0, 10) : 0;
      noise_ch.ready <= (gap == 0);
      repeat (gap) @(posedge clk);
      noise_ch.ready <= 1'b1;
      do @(posedge clk); while (!noise_ch.valid);
    end
  end

  task automatic apb_write(input fvn_pkg::cfg_reg_e which, input logic [63:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= fvn_pkg::CFG_AW'(which) << 3; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (which == fvn_pkg::REG_SEED) seed_shadow <= value;
    else salt_shadow <= value[15:0];
    @(posedge clk);
  endtask

  task automatic send_cell(input logic [15:0] x, input logic [15:0] y, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_ch.valid <= 1'b1; cell_ch.cell_x <= x; cell_ch.cell_y <= y;
    do @(posedge clk); while (!cell_ch.ready);
  endtask

  // Let the checker record the last transfer, then wait until nothing is in flight
  task automatic drain();
    cell_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    logic [63:0] seeds[4];
    logic [15:0] salts[4];
    logic [15:0] edge_vals[6];
    cell_ch.valid = 1'b0; cell_ch.cell_x = '0; cell_ch.cell_y = '0;
    seeds = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom}, {$urandom, $urandom}};
    salts = '{16'd0, 16'hFFFF, 16'hFFFE, 16'($urandom)};
    edge_vals = '{16'd0, 16'd1, 16'd16, 16'h7FFF, 16'hFFFE, 16'hFFFF};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: coordinate extremes under reset configuration
    foreach (edge_vals[i])
      foreach (edge_vals[j])
        if ((i + j) % 2 == 0 || i == j) send_cell(edge_vals[i], edge_vals[j], 1'b0);
    drain();

    // Random phases over several seed/salt settings
    for (int p = 0; p < 4; p++) begin
      apb_write(fvn_pkg::REG_SEED, seeds[p]);
      apb_write(fvn_pkg::REG_SALT, salts[p]);
      stall_on = (p != 2);
      for (int n = 0; n < 420; n++)
        send_cell(16'($urandom), 16'($urandom), p != 1 && n % 50 < 40);
      drain();
    end

    if (fail_count == 0) begin
      $display("** fractal_value_noise_2d: PASSED **");
    end else begin
      $display("** fractal_value_noise_2d: FAILED **");
    end
    $finish;
  end
endmodule
